/* rtl/msg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_pkg
// Shared types, constants and helper functions of the mass-spring grid core.
// ----------------------------------------------------------------------------
package msg_pkg;

    localparam int GRID_W_DEF = 7;
    localparam int GRID_H_DEF = 5;

    localparam logic [31:0] HALF_Q   = 32'd8388608;
    localparam logic [31:0] TWO_Q    = 32'd33554432;
    localparam logic [31:0] LAT_STEP = 32'd3355443;
    localparam logic [31:0] SPRING_TOL = 32'd17;
    localparam logic [27:0] REST_RST = 28'd3355443;
    localparam logic [24:0] GAIN_RST = 25'd5033165;
    localparam logic [24:0] DAMP_RST = 25'd16609444;
    localparam int NUM_W = 59;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_TICK  = 2'd1,
        FN_READ  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_REST = 2'd0,
        CFG_GAIN = 2'd1,
        CFG_DAMP = 2'd2
    } t_cfg;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RD_WAIT, S_SELF, S_NB_SEL, S_NB_WAIT, S_SQ, S_SQ_ADD,
        S_SQRT_GO, S_SQRT, S_LEN, S_Q_MUL, S_Q_DIV_GO, S_Q_DIV, S_NB_ACC,
        S_G_MUL, S_G_RES, S_F_WR, S_U_ADD, S_U_POS, S_U_MUL, S_U_RES, S_U_WR,
        S_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    // round(n * 0.2) in q8.24, valid for n below 64
    function automatic logic [31:0] lat_off(input logic [5:0] n);
        logic [15:0] m;
        m = 16'((10'({n, 1'b0}) + 10'd5) * 16'd205);
        return 32'(32'(n) * LAT_STEP) + 32'(m >> 11);
    endfunction

endpackage

/* rtl/msg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_in_if
// Command channel of the grid core: function, particle index and vector.
// ----------------------------------------------------------------------------
interface msg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [5:0]         index;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;

    modport source(output valid, func, index, in_x, in_y, in_z, input ready);
    modport sink(input valid, func, index, in_x, in_y, in_z, output ready);
endinterface

/* rtl/msg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_out_if
// Result channel of the grid core: position, velocity and status.
// ----------------------------------------------------------------------------
interface msg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_px;
    logic signed [31:0] out_py;
    logic signed [31:0] out_pz;
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic signed [31:0] out_vz;
    logic               status;

    modport source(output valid, out_px, out_py, out_pz, out_vx, out_vy, out_vz,
                   status, input ready);
    modport sink(input valid, out_px, out_py, out_pz, out_vx, out_vy, out_vz,
                 status, output ready);
endinterface

/* rtl/msg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msg_ram #(
    parameter int W     = 96,
    parameter int DEPTH = 35
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/msg_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module msg_sqrt
    import msg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_v, n_v;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;

    always_comb begin
        logic [63:0] t;
        t      = r_res + r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_v    = i_val;
            n_res  = '0;
            n_bit  = 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= t) begin
                n_v   = r_v - t;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

/* rtl/msg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msg_div
    import msg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [5:0]       r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_den, n_den;

    always_comb begin
        logic [32:0] sh;
        sh     = {r_rem, r_num[NUM_W-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_quo  = '0;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                n_rem = 32'(sh - {1'b0, r_den});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = sh[31:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_num = r_num << 1;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* rtl/mass_spring_grid_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mass_spring_grid_step_core
// Mass-spring particle grid: write, read and explicit Euler tick on RAMs.
// ----------------------------------------------------------------------------
// One command word on i_in gives exactly one result word on o_out. Write
// stores a particle position, read returns position and velocity, tick
// advances the grid. A tick first walks every particle and its neighbors
// for the spring force, then walks every row but the first to update
// velocity and position. The cost of each spring is set by the
// one-bit-per-cycle square root and, above tolerance only, the divider,
// run once per axis. The default grid is 7x5.
// One command is worked on at a time.
// After reset the position and velocity RAMs are loaded with the rest
// lattice and zero velocity, one particle per cycle, with i_in.ready low;
// register writes are taken at any time. A stalled result sits in the
// output register while the next command is already accepted.
// ----------------------------------------------------------------------------
module mass_spring_grid_step_core
    import msg_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [27:0] i_cfg_wdata,
    msg_in_if.sink      i_in,
    msg_out_if.source   o_out
);
    localparam int NPART = GRID_W * GRID_H;
    localparam int AW = $clog2(NPART);
    localparam int CW = $clog2(GRID_W);
    localparam int RW = $clog2(GRID_H);

    t_state r_state, n_state;
    logic [27:0] r_rest;
    logic [24:0] r_gain, r_damp;

    logic [AW-1:0] r_k, n_k;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [1:0]    r_nb, n_nb;
    logic [1:0]    r_c, n_c;
    logic          r_rd, n_rd;
    logic          r_bad, n_bad;
    logic          r_tneg, n_tneg;
    logic signed [31:0] r_acc [3], n_acc [3];
    logic signed [31:0] r_self [3], n_self [3];
    logic signed [31:0] r_d [3], n_d [3];
    logic signed [31:0] r_v [3], n_v [3];
    logic signed [31:0] r_p [3], n_p [3];
    logic signed [33:0] r_sum [3], n_sum [3];
    logic [63:0]        r_ss, n_ss;
    logic [31:0]        r_len, n_len;
    logic signed [65:0] r_prod;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;

    logic          r_ov, n_ov;
    logic signed [31:0] r_op [3], n_op [3];
    logic signed [31:0] r_ovl [3], n_ovl [3];
    logic          r_ost, n_ost;

    logic [AW-1:0] raddr, waddr;
    logic [95:0]   pos_wd, vel_wd;
    logic          pos_we, vel_we, frc_we;
    logic [95:0]   pos_rd, vel_rd, frc_rd;

    logic              sq_start, sq_done;
    logic [31:0]       sq_root;
    logic              dv_start, dv_done;
    logic [NUM_W-1:0]  dv_quo;
    logic [NUM_W-1:0]  dv_num;

    msg_ram #(.W(96), .DEPTH(NPART)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(waddr), .i_wdata(pos_wd),
        .i_raddr(raddr), .o_rdata(pos_rd)
    );
    msg_ram #(.W(96), .DEPTH(NPART)) u_vel (
        .i_clk(i_clk), .i_we(vel_we), .i_waddr(waddr), .i_wdata(vel_wd),
        .i_raddr(raddr), .o_rdata(vel_rd)
    );
    msg_ram #(.W(96), .DEPTH(NPART)) u_frc (
        .i_clk(i_clk), .i_we(frc_we), .i_waddr(waddr), .i_wdata(vel_wd),
        .i_raddr(raddr), .o_rdata(frc_rd)
    );

    msg_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(r_ss),
        .o_done(sq_done), .o_root(sq_root)
    );

    assign dv_num = r_prod[65] ? NUM_W'(-r_prod) : NUM_W'(r_prod);

    msg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(dv_num),
        .i_den(r_len), .o_done(dv_done), .o_quo(dv_quo)
    );

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ: begin
                mul_a = 34'(r_d[r_c]);
                mul_b = r_d[r_c];
            end
            S_Q_MUL: begin
                mul_a = 34'(r_d[r_c]);
                mul_b = $signed({4'b0, r_rest});
            end
            S_G_MUL: begin
                mul_a = r_sum[r_c];
                mul_b = $signed({7'b0, r_gain});
            end
            S_U_MUL: begin
                mul_a = 34'(r_v[r_c]);
                mul_b = $signed({7'b0, r_damp});
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(mul_a * mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= REST_RST;
            r_gain <= GAIN_RST;
            r_damp <= DAMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REST: r_rest <= i_cfg_wdata;
                CFG_GAIN: r_gain <= i_cfg_wdata[24:0];
                CFG_DAMP: r_damp <= i_cfg_wdata[24:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic          nb_ok;
        logic [AW-1:0] nb_addr;
        logic signed [31:0] pw [3];
        logic signed [31:0] vw [3];
        logic signed [31:0] fw [3];
        logic signed [59:0] q;
        logic          acc_in;
        logic          idx_ok;
        logic [CW-1:0] nxt_col;
        logic [RW-1:0] nxt_row;

        for (int i = 0; i < 3; i++) begin
            pw[i] = pos_rd[95-32*i -: 32];
            vw[i] = vel_rd[95-32*i -: 32];
            fw[i] = frc_rd[95-32*i -: 32];
        end
        q      = r_tneg ? -60'(dv_quo) : 60'(dv_quo);
        acc_in = i_in.valid && i_in.ready;
        idx_ok = 32'(i_in.index) < NPART;
        nxt_col = (r_col == CW'(GRID_W - 1)) ? '0 : r_col + CW'(1);
        nxt_row = (r_col == CW'(GRID_W - 1)) ? r_row + RW'(1) : r_row;

        unique case (r_nb)
            2'd0: begin nb_ok = r_col != '0;                  nb_addr = r_k - AW'(1); end
            2'd1: begin nb_ok = r_col != CW'(GRID_W - 1);     nb_addr = r_k + AW'(1); end
            2'd2: begin nb_ok = r_row != '0;                  nb_addr = r_k - AW'(GRID_W); end
            default: begin
                nb_ok = r_row != RW'(GRID_H - 1);
                nb_addr = r_k + AW'(GRID_W);
            end
        endcase

        n_state = r_state;
        n_k = r_k; n_col = r_col; n_row = r_row; n_nb = r_nb; n_c = r_c;
        n_rd = r_rd; n_bad = r_bad; n_tneg = r_tneg;
        n_acc = r_acc; n_self = r_self; n_d = r_d; n_v = r_v; n_p = r_p;
        n_sum = r_sum; n_ss = r_ss; n_len = r_len;
        n_ov = r_ov; n_op = r_op; n_ovl = r_ovl; n_ost = r_ost;
        raddr = r_k; waddr = r_k;
        pos_we = 1'b0; vel_we = 1'b0; frc_we = 1'b0;
        pos_wd = {r_p[0], r_p[1], r_p[2]};
        vel_wd = {r_v[0], r_v[1], r_v[2]};
        sq_start = 1'b0; dv_start = 1'b0;
        i_in.ready = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                pos_we = 1'b1;
                vel_we = 1'b1;
                pos_wd = {HALF_Q, TWO_Q - lat_off(6'(r_col)), TWO_Q - lat_off(6'(r_row))};
                vel_wd = '0;
                n_col = nxt_col;
                n_row = nxt_row;
                n_k = r_k + AW'(1);
                if (r_k == AW'(NPART - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                n_rd = 1'b0;
                n_bad = 1'b0;
                n_k = '0; n_col = '0; n_row = '0;
                raddr = '0;
                if (acc_in) begin
                    n_state = S_DONE;
                    case (i_in.func)
                        FN_WRITE: begin
                            n_bad = !idx_ok;
                            waddr = AW'(i_in.index);
                            pos_we = idx_ok;
                            pos_wd = {i_in.in_x, i_in.in_y, i_in.in_z};
                        end
                        FN_READ: begin
                            n_bad = !idx_ok;
                            raddr = AW'(i_in.index);
                            if (idx_ok) begin
                                n_rd = 1'b1;
                                n_state = S_RD_WAIT;
                            end
                        end
                        FN_TICK: begin
                            n_acc[0] = i_in.in_x;
                            n_acc[1] = i_in.in_y;
                            n_acc[2] = i_in.in_z;
                            n_state = S_SELF;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_p = pw;
                n_v = vw;
                n_state = S_DONE;
            end
            S_SELF: begin
                n_self = pw;
                for (int i = 0; i < 3; i++) n_sum[i] = '0;
                n_nb = '0;
                n_state = S_NB_SEL;
            end
            S_NB_SEL: begin
                raddr = nb_addr;
                if (nb_ok) begin
                    n_state = S_NB_WAIT;
                end else if (r_nb == 2'd3) begin
                    n_c = '0;
                    n_state = S_G_MUL;
                end else begin
                    n_nb = r_nb + 2'd1;
                end
            end
            S_NB_WAIT: begin
                for (int i = 0; i < 3; i++) n_d[i] = sat32(66'(pw[i]) - 66'(r_self[i]));
                n_ss = '0;
                n_c = '0;
                n_state = S_SQ;
            end
            S_SQ: n_state = S_SQ_ADD;
            S_SQ_ADD: begin
                n_ss = r_ss + r_prod[63:0];
                n_c = r_c + 2'd1;
                n_state = (r_c == 2'd2) ? S_SQRT_GO : S_SQ;
            end
            S_SQRT_GO: begin
                sq_start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_len = sq_root;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_c = '0;
                n_state = (r_len > SPRING_TOL) ? S_Q_MUL : S_NB_ACC;
            end
            S_Q_MUL: n_state = S_Q_DIV_GO;
            S_Q_DIV_GO: begin
                dv_start = 1'b1;
                n_tneg = r_prod[65];
                n_state = S_Q_DIV;
            end
            S_Q_DIV: begin
                if (dv_done) begin
                    n_d[r_c] = sat32(66'(r_d[r_c]) - 66'(q));
                    n_c = r_c + 2'd1;
                    n_state = (r_c == 2'd2) ? S_NB_ACC : S_Q_MUL;
                end
            end
            S_NB_ACC: begin
                for (int i = 0; i < 3; i++) n_sum[i] = r_sum[i] + 34'(r_d[i]);
                n_c = '0;
                n_nb = r_nb + 2'd1;
                n_state = (r_nb == 2'd3) ? S_G_MUL : S_NB_SEL;
            end
            S_G_MUL: n_state = S_G_RES;
            S_G_RES: begin
                n_v[r_c] = sat32((r_prod + 66'sd8388608) >>> 24);
                n_c = r_c + 2'd1;
                n_state = (r_c == 2'd2) ? S_F_WR : S_G_MUL;
            end
            S_F_WR: begin
                frc_we = 1'b1;
                n_col = nxt_col;
                n_row = nxt_row;
                if (r_k == AW'(NPART - 1)) begin
                    n_k = AW'(GRID_W);
                    raddr = AW'(GRID_W);
                    n_state = S_U_ADD;
                end else begin
                    n_k = r_k + AW'(1);
                    raddr = r_k + AW'(1);
                    n_state = S_SELF;
                end
            end
            S_U_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    n_v[i] = sat32(66'(vw[i]) + 66'(r_acc[i]) + 66'(fw[i]));
                end
                n_p = pw;
                n_state = S_U_POS;
            end
            S_U_POS: begin
                for (int i = 0; i < 3; i++) n_p[i] = sat32(66'(r_p[i]) + 66'(r_v[i]));
                n_c = '0;
                n_state = S_U_MUL;
            end
            S_U_MUL: n_state = S_U_RES;
            S_U_RES: begin
                n_d[r_c] = sat32((r_prod + 66'sd8388608) >>> 24);
                n_c = r_c + 2'd1;
                n_state = (r_c == 2'd2) ? S_U_WR : S_U_MUL;
            end
            S_U_WR: begin
                pos_we = 1'b1;
                vel_we = 1'b1;
                vel_wd = {r_d[0], r_d[1], r_d[2]};
                if (r_k == AW'(NPART - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + AW'(1);
                    raddr = r_k + AW'(1);
                    n_state = S_U_ADD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_ost = r_bad;
                    for (int i = 0; i < 3; i++) begin
                        n_op[i] = r_rd ? r_p[i] : '0;
                        n_ovl[i] = r_rd ? r_v[i] : '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_nb    <= '0;
            r_c     <= '0;
            r_rd    <= 1'b0;
            r_bad   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_col   <= n_col;
            r_row   <= n_row;
            r_nb    <= n_nb;
            r_c     <= n_c;
            r_rd    <= n_rd;
            r_bad   <= n_bad;
            r_ov    <= n_ov;
        end
        r_tneg <= n_tneg;
        r_acc  <= n_acc;
        r_self <= n_self;
        r_d    <= n_d;
        r_v    <= n_v;
        r_p    <= n_p;
        r_sum  <= n_sum;
        r_ss   <= n_ss;
        r_len  <= n_len;
        r_op   <= n_op;
        r_ovl  <= n_ovl;
        r_ost  <= n_ost;
    end

    assign o_out.valid  = r_ov;
    assign o_out.out_px = r_op[0];
    assign o_out.out_py = r_op[1];
    assign o_out.out_pz = r_op[2];
    assign o_out.out_vx = r_ovl[0];
    assign o_out.out_vy = r_ovl[1];
    assign o_out.out_vz = r_ovl[2];
    assign o_out.status = r_ost;

    a_clr_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_in.ready)
        else $error("command taken during lattice load");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(frc_we && pos_we))
        else $error("force and position written together");

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT))
        else $error("square root finished outside its wait state");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> (r_state == S_Q_DIV))
        else $error("divider finished outside its wait state");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ov) |=> r_ov)
        else $error("finished word not loaded into output register");
endmodule
